@@ rtl/core/fix_message_deframer_unit_defines.svh @@
// ----------------------------------------------------------------------------
// fix_message_deframer_unit_defines
// Assertion macros used by the deframer parser.
// ----------------------------------------------------------------------------
`ifndef FIX_MESSAGE_DEFRAMER_UNIT_DEFINES_SVH
`define FIX_MESSAGE_DEFRAMER_UNIT_DEFINES_SVH

// Property that must hold at every clock edge out of reset.
`define FMD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Antecedent in this cycle implies consequent in the next one.
`define FMD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/fmd_pkg.sv @@
// ----------------------------------------------------------------------------
// fmd_pkg
// Types and constants for the tag=value message deframer.
// ----------------------------------------------------------------------------
package fmd_pkg;

  localparam int unsigned LENGTH_WIDTH_DEF = 20;
  localparam int unsigned TAG_WIDTH_DEF    = 20;

  // fixed widths of the result fields and the limit register
  localparam int unsigned OUT_W   = 20;
  localparam int unsigned LIMIT_W = 20;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = LIMIT_W;

  localparam logic [7:0] SOH_BYTE   = 8'h01;
  localparam logic [7:0] EQ_BYTE    = 8'h3D;
  localparam logic [7:0] EIGHT_BYTE = 8'h38;
  localparam logic [7:0] ZERO_BYTE  = 8'h30;
  localparam logic [7:0] NINE_BYTE  = 8'h39;

  typedef enum logic [2:0] {
    EV_VALUE     = 3'd0,
    EV_FIELD_END = 3'd1,
    EV_MSG_OK    = 3'd2,
    EV_BAD_SUM   = 3'd3,
    EV_BAD_LEN   = 3'd4,
    EV_OVER_LIM  = 3'd5,
    EV_MALFORMED = 3'd6
  } event_e;

  typedef enum logic [2:0] {
    PH_HUNT  = 3'b001,
    PH_TAG   = 3'b010,
    PH_VALUE = 3'b100
  } phase_e;

  typedef enum logic [3:0] {
    HS_TAG8 = 4'b0001,
    HS_TAG9 = 4'b0010,
    HS_BODY = 4'b0100,
    HS_CSUM = 4'b1000
  } hdr_step_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SUM_EN = 2'd0,
    CFG_LEN_EN = 2'd1,
    CFG_LIMIT  = 2'd2
  } cfg_index_e;

  typedef struct packed {
    logic               sum_en;
    logic               len_en;
    logic [LIMIT_W-1:0] limit;
  } cfg_t;

  typedef struct packed {
    logic             valid;
    event_e           ev;
    logic [OUT_W-1:0] tag;
    logic [7:0]       data;
    logic [OUT_W-1:0] bytes;
    logic [7:0]       sum;
  } res_t;

endpackage

@@ rtl/core/fmd_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// fmd_cfg_regs
// Configuration register bank of the deframer.
// ----------------------------------------------------------------------------
module fmd_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [fmd_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [fmd_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output fmd_pkg::cfg_t                    cfg_o
);

  fmd_pkg::cfg_t cfg_d, cfg_q;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        fmd_pkg::CFG_SUM_EN: cfg_d.sum_en = cfg_data_i[0];
        fmd_pkg::CFG_LEN_EN: cfg_d.len_en = cfg_data_i[0];
        fmd_pkg::CFG_LIMIT:  cfg_d.limit  = cfg_data_i[fmd_pkg::LIMIT_W-1:0];
        default: ;  // unmapped index, word dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sum_en <= 1'b1;
      cfg_q.len_en <= 1'b1;
      cfg_q.limit  <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/core/fmd_parser.sv @@
// ----------------------------------------------------------------------------
// fmd_parser
// Per-byte tag/value parser: state registers and next-state logic.
// ----------------------------------------------------------------------------
`include "fix_message_deframer_unit_defines.svh"

module fmd_parser #(
  parameter int unsigned LENGTH_WIDTH = fmd_pkg::LENGTH_WIDTH_DEF,
  parameter int unsigned TAG_WIDTH    = fmd_pkg::TAG_WIDTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_accept_i,
  input  logic [7:0]    in_byte_i,
  input  fmd_pkg::cfg_t cfg_i,
  output fmd_pkg::res_t res_o
);

  localparam int unsigned LW = LENGTH_WIDTH;
  localparam int unsigned TW = TAG_WIDTH;
  localparam int unsigned CW = (LW > fmd_pkg::LIMIT_W) ? LW : fmd_pkg::LIMIT_W;

  fmd_pkg::phase_e    phase_d, phase_q;
  fmd_pkg::hdr_step_e step_d, step_q;
  logic [TW-1:0]      tag_d, tag_q;
  logic               has_digit_d, has_digit_q;
  logic [LW-1:0]      num_d, num_q;
  logic [LW-1:0]      decl_d, decl_q;
  logic [7:0]         rsum_d, rsum_q;
  logic [7:0]         fsum_d, fsum_q;
  logic [LW-1:0]      body_d, body_q;
  logic [LW-1:0]      fbody_d, fbody_q;
  logic [LW-1:0]      bcnt_d, bcnt_q;
  logic               last_soh_d, last_soh_q;

  logic          is_soh, is_digit, is_eq;
  logic [3:0]    dval;
  logic [TW+3:0] tag_ext, tag_mul;
  logic [LW+3:0] num_ext, num_mul;
  logic [TW-1:0] tag_sat;
  logic [LW-1:0] num_sat;
  logic [LW-1:0] bcnt_inc, body_inc;
  logic          over_limit;
  logic          begin_fld;

  assign is_soh   = (in_byte_i == fmd_pkg::SOH_BYTE);
  assign is_eq    = (in_byte_i == fmd_pkg::EQ_BYTE);
  assign is_digit = (in_byte_i >= fmd_pkg::ZERO_BYTE) && (in_byte_i <= fmd_pkg::NINE_BYTE);
  // ASCII digits sit at 0x30..0x39, so the low nibble is the digit value
  assign dval     = in_byte_i[3:0];

  // acc*10 + d, saturated when it spills past the register width
  assign tag_ext = {4'b0000, tag_q};
  assign tag_mul = (tag_ext << 3) + (tag_ext << 1) + {{TW{1'b0}}, dval};
  assign tag_sat = (tag_mul[TW+3:TW] != 4'b0000) ? {TW{1'b1}} : tag_mul[TW-1:0];

  assign num_ext = {4'b0000, num_q};
  assign num_mul = (num_ext << 3) + (num_ext << 1) + {{LW{1'b0}}, dval};
  assign num_sat = (num_mul[LW+3:LW] != 4'b0000) ? {LW{1'b1}} : num_mul[LW-1:0];

  assign bcnt_inc = (bcnt_q == {LW{1'b1}}) ? bcnt_q : bcnt_q + 1'b1;
  assign body_inc = (body_q == {LW{1'b1}}) ? body_q : body_q + 1'b1;

  assign over_limit = (cfg_i.limit != '0) && (CW'(num_q) > CW'(cfg_i.limit));

  always_comb begin
    phase_d     = phase_q;
    step_d      = step_q;
    tag_d       = tag_q;
    has_digit_d = has_digit_q;
    num_d       = num_q;
    decl_d      = decl_q;
    rsum_d      = rsum_q;
    fsum_d      = fsum_q;
    body_d      = body_q;
    fbody_d     = fbody_q;
    bcnt_d      = bcnt_q;
    last_soh_d  = is_soh;
    begin_fld   = 1'b0;

    res_o.valid = 1'b0;
    res_o.ev    = fmd_pkg::EV_VALUE;
    res_o.data  = 8'h00;

    unique case (phase_q)
      fmd_pkg::PH_HUNT: begin
        if (last_soh_q && (in_byte_i == fmd_pkg::EIGHT_BYTE)) begin
          step_d      = fmd_pkg::HS_TAG8;
          phase_d     = fmd_pkg::PH_TAG;
          decl_d      = '0;
          body_d      = '0;
          bcnt_d      = LW'(1);
          rsum_d      = in_byte_i;
          fsum_d      = 8'h00;
          fbody_d     = '0;
          num_d       = '0;
          tag_d       = TW'(8);
          has_digit_d = 1'b1;
        end
      end

      fmd_pkg::PH_TAG: begin
        bcnt_d = bcnt_inc;
        rsum_d = rsum_q + in_byte_i;
        if ((step_q == fmd_pkg::HS_BODY) || (step_q == fmd_pkg::HS_CSUM)) begin
          body_d = body_inc;
        end
        priority if (is_digit) begin
          tag_d       = tag_sat;
          has_digit_d = 1'b1;
        end else if (is_eq && has_digit_q &&
                     !((step_q == fmd_pkg::HS_TAG8) && (tag_q != TW'(8))) &&
                     !((step_q == fmd_pkg::HS_TAG9) && (tag_q != TW'(9)))) begin
          phase_d = fmd_pkg::PH_VALUE;
          num_d   = '0;
          if (((step_q == fmd_pkg::HS_BODY) || (step_q == fmd_pkg::HS_CSUM)) &&
              (tag_q == TW'(10))) begin
            step_d = fmd_pkg::HS_CSUM;
          end
        end else begin
          phase_d     = fmd_pkg::PH_HUNT;
          res_o.valid = 1'b1;
          res_o.ev    = fmd_pkg::EV_MALFORMED;
        end
      end

      fmd_pkg::PH_VALUE: begin
        bcnt_d = bcnt_inc;
        rsum_d = rsum_q + in_byte_i;
        if ((step_q == fmd_pkg::HS_BODY) || (step_q == fmd_pkg::HS_CSUM)) begin
          body_d = body_inc;
        end
        res_o.valid = 1'b1;
        if (!is_soh) begin
          // length and checksum values must be decimal
          if (((step_q == fmd_pkg::HS_TAG9) || (step_q == fmd_pkg::HS_CSUM)) && !is_digit) begin
            phase_d  = fmd_pkg::PH_HUNT;
            res_o.ev = fmd_pkg::EV_MALFORMED;
          end else begin
            if ((step_q == fmd_pkg::HS_TAG9) || (step_q == fmd_pkg::HS_CSUM)) begin
              num_d = num_sat;
            end
            res_o.ev   = fmd_pkg::EV_VALUE;
            res_o.data = in_byte_i;
          end
        end else begin
          unique case (step_q)
            fmd_pkg::HS_TAG8: begin
              res_o.ev  = fmd_pkg::EV_FIELD_END;
              step_d    = fmd_pkg::HS_TAG9;
              begin_fld = 1'b1;
            end
            fmd_pkg::HS_TAG9: begin
              decl_d = num_q;
              if (over_limit) begin
                phase_d  = fmd_pkg::PH_HUNT;
                res_o.ev = fmd_pkg::EV_OVER_LIM;
              end else begin
                res_o.ev  = fmd_pkg::EV_FIELD_END;
                step_d    = fmd_pkg::HS_BODY;
                begin_fld = 1'b1;
              end
            end
            fmd_pkg::HS_BODY: begin
              res_o.ev  = fmd_pkg::EV_FIELD_END;
              begin_fld = 1'b1;
            end
            default: begin
              // checksum field closed: checksum first, then body length
              phase_d = fmd_pkg::PH_HUNT;
              priority if (cfg_i.sum_en && (fsum_q != num_q[7:0])) begin
                res_o.ev = fmd_pkg::EV_BAD_SUM;
              end else if (cfg_i.len_en && (fbody_q != decl_q)) begin
                res_o.ev = fmd_pkg::EV_BAD_LEN;
              end else begin
                res_o.ev = fmd_pkg::EV_MSG_OK;
              end
            end
          endcase
        end
      end

      default: phase_d = fmd_pkg::PH_HUNT;
    endcase

    if (begin_fld) begin
      phase_d     = fmd_pkg::PH_TAG;
      tag_d       = '0;
      has_digit_d = 1'b0;
      num_d       = '0;
      fsum_d      = rsum_d;
      fbody_d     = body_d;
    end

    res_o.tag   = fmd_pkg::OUT_W'(tag_q);
    res_o.bytes = fmd_pkg::OUT_W'(bcnt_d);
    res_o.sum   = fsum_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= fmd_pkg::PH_HUNT;
      step_q      <= fmd_pkg::HS_TAG8;
      tag_q       <= '0;
      has_digit_q <= 1'b0;
      num_q       <= '0;
      decl_q      <= '0;
      rsum_q      <= '0;
      fsum_q      <= '0;
      body_q      <= '0;
      fbody_q     <= '0;
      bcnt_q      <= '0;
      last_soh_q  <= 1'b1;
    end else if (in_accept_i) begin
      phase_q     <= phase_d;
      step_q      <= step_d;
      tag_q       <= tag_d;
      has_digit_q <= has_digit_d;
      num_q       <= num_d;
      decl_q      <= decl_d;
      rsum_q      <= rsum_d;
      fsum_q      <= fsum_d;
      body_q      <= body_d;
      fbody_q     <= fbody_d;
      bcnt_q      <= bcnt_d;
      last_soh_q  <= last_soh_d;
    end
  end

  // verdicts and errors always drop back to hunting
  `FMD_ASSERT_NEXT(a_verdict_hunts,
    in_accept_i && res_o.valid && (res_o.ev != fmd_pkg::EV_VALUE) &&
    (res_o.ev != fmd_pkg::EV_FIELD_END),
    phase_q == fmd_pkg::PH_HUNT, "verdict did not return to hunting")
  `FMD_ASSERT(a_data_zero,
    !res_o.valid || (res_o.ev == fmd_pkg::EV_VALUE) || (res_o.data == 8'h00),
    "data byte set on a non-value word")
  `FMD_ASSERT(a_count_live,
    (phase_q == fmd_pkg::PH_HUNT) || (bcnt_q != '0),
    "byte count zero inside a message")

endmodule

@@ rtl/core/fmd_out_reg.sv @@
// ----------------------------------------------------------------------------
// fmd_out_reg
// Result register between the parser and the output stream.
// ----------------------------------------------------------------------------
module fmd_out_reg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_i,
  input  fmd_pkg::res_t res_i,
  input  logic          m_tready_i,
  output logic          free_o,
  output fmd_pkg::res_t res_o
);

  logic          valid_d, valid_q;
  fmd_pkg::res_t pay_q;

  // slot may be refilled in the cycle it is drained
  assign free_o = !valid_q || m_tready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (m_tready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      pay_q <= res_i;
    end
  end

  always_comb begin
    res_o       = pay_q;
    res_o.valid = valid_q;
  end

endmodule

@@ rtl/core/fix_message_deframer_unit.sv @@
// ----------------------------------------------------------------------------
// fix_message_deframer_unit
// Streaming deframer for SOH-delimited tag=value messages.
//
// Bytes enter on the s_axis channel, one word per byte. Each byte updates the
// parser state in the cycle it is accepted; a byte that gives a result puts
// it into the output register, seen on m_axis in the next cycle. Results are
// value bytes, field ends and one verdict per message (ok, bad checksum,
// bad length, over limit, malformed). Throughput is one byte per cycle while
// the output register is free; the loop that sets it is the parser state update.
// s_axis_tready_o is high whenever the output register is empty or is being
// taken, so a stalled receiver holds back input only while a result waits.
// While a result waits, every byte is held, even one that gives no result.
// The cfg channel is always ready; write it only while the block is idle.
// Reset puts the parser into hunting for an '8' at stream start, enables
// both checks and clears the length limit. No clearing pass is needed.
// ----------------------------------------------------------------------------
module fix_message_deframer_unit #(
  parameter int unsigned LENGTH_WIDTH = fmd_pkg::LENGTH_WIDTH_DEF,
  parameter int unsigned TAG_WIDTH    = fmd_pkg::TAG_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // in_byte[7:0]
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [7:0]                     s_axis_tdata_i,
  // field_tag[19:0], data_byte[27:20], message_bytes[47:28], sum_computed[55:48]
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  output logic [55:0]                    m_axis_tdata_o,
  // event_res[2:0]
  output logic [2:0]                     m_axis_tuser_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [fmd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [fmd_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  fmd_pkg::cfg_t cfg;
  fmd_pkg::res_t res_new, res_out;
  logic          in_accept;
  logic          out_free;

  assign s_axis_tready_o = out_free;
  assign in_accept       = s_axis_tvalid_i && out_free;

  fmd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  fmd_parser #(
    .LENGTH_WIDTH (LENGTH_WIDTH),
    .TAG_WIDTH    (TAG_WIDTH)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_accept_i (in_accept),
    .in_byte_i   (s_axis_tdata_i),
    .cfg_i       (cfg),
    .res_o       (res_new)
  );

  fmd_out_reg u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (in_accept && res_new.valid),
    .res_i      (res_new),
    .m_tready_i (m_axis_tready_i),
    .free_o     (out_free),
    .res_o      (res_out)
  );

  assign m_axis_tvalid_o = res_out.valid;
  assign m_axis_tuser_o  = res_out.ev;
  assign m_axis_tdata_o  = {res_out.sum, res_out.bytes, res_out.data, res_out.tag};

endmodule

@@ verif/fix_message_deframer_unit_tb.sv @@
// ----------------------------------------------------------------------------
// fix_message_deframer_unit_tb
// Self-checking bench for the tag=value message deframer. Builds byte
// streams of whole messages (clean, damaged, cut short) mixed with noise,
// runs them through under random sender bursts and receiver stalls, and
// checks every output word against an in-bench parser model. The run steps
// through several check and length limit settings.
// ----------------------------------------------------------------------------
module fix_message_deframer_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam logic [19:0] SAT20       = 20'hFFFFF;
  localparam logic [7:0]  LETTER_A    = 8'h41;
  localparam logic [7:0]  DOT_BYTE    = 8'h2E;

  typedef struct {
    fmd_pkg::event_e ev;
    logic [19:0]     tag;
    logic [7:0]      data;
    logic [19:0]     nbytes;
    logic [7:0]      sum;
  } deframe_event_t;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i  = 8'h00;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [55:0] m_axis_tdata_o;
  logic [2:0]  m_axis_tuser_o;
  logic        cfg_valid_i     = 1'b0;
  logic        cfg_ready_o;
  logic [fmd_pkg::CFG_IDX_W-1:0]  cfg_index_i = fmd_pkg::CFG_SUM_EN;
  logic [fmd_pkg::CFG_DATA_W-1:0] cfg_data_i  = '0;

  fix_message_deframer_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  logic [7:0]     stream_bytes[$];
  logic [7:0]     frame_buf[$];
  deframe_event_t predicted_events[$];
  deframe_event_t want;
  int unsigned    items_sent     = 0;
  int unsigned    mismatch_count = 0;
  int unsigned    cycle_count    = 0;
  int unsigned    burst_left     = 0;
  int unsigned    gap_left       = 0;

  // parser shadow, reset values
  logic                 sh_sum_en     = 1'b1;
  logic                 sh_len_en     = 1'b1;
  logic [19:0]          sh_limit      = '0;
  fmd_pkg::phase_e      sh_phase      = fmd_pkg::PH_HUNT;
  fmd_pkg::hdr_step_e   sh_step       = fmd_pkg::HS_TAG8;
  logic [19:0]          sh_tag        = '0;
  logic                 sh_has_digit  = 1'b0;
  logic [19:0]          sh_num        = '0;
  logic [19:0]          sh_declared   = '0;
  logic [7:0]           sh_sum        = '0;
  logic [7:0]           sh_sum_start  = '0;
  logic [19:0]          sh_body       = '0;
  logic [19:0]          sh_body_start = '0;
  logic [19:0]          sh_count      = '0;
  logic                 sh_last_soh   = 1'b1;

  function automatic void frame_add(input logic [7:0] b);
    frame_buf = {frame_buf, b};
  endfunction

  function automatic void stream_add(input logic [7:0] b);
    stream_bytes = {stream_bytes, b};
  endfunction

  function automatic logic [19:0] add_digit(input logic [19:0] acc, input logic [7:0] ch);
    int unsigned d;
    d = 32'(ch - fmd_pkg::ZERO_BYTE);
    if (acc > (SAT20 - d) / 10) return SAT20;
    return 20'(acc * 10 + d);
  endfunction

  function automatic logic [19:0] bump(input logic [19:0] v);
    return (v == SAT20) ? v : v + 20'd1;
  endfunction

  function automatic void post_event(input fmd_pkg::event_e ev, input logic [7:0] d);
    deframe_event_t e;
    e = '{ev, sh_tag, d, sh_count, sh_sum_start};
    predicted_events = {predicted_events, e};
  endfunction

  function automatic void open_field();
    sh_phase      = fmd_pkg::PH_TAG;
    sh_tag        = '0;
    sh_has_digit  = 1'b0;
    sh_num        = '0;
    sh_sum_start  = sh_sum;
    sh_body_start = sh_body;
  endfunction

  // advance the shadow parser by one accepted byte
  function automatic void parse_byte(input logic [7:0] b);
    logic            is_soh, is_digit, prev_soh, hdr_ok;
    fmd_pkg::event_e verdict;
    is_soh      = (b == fmd_pkg::SOH_BYTE);
    is_digit    = (b >= fmd_pkg::ZERO_BYTE) && (b <= fmd_pkg::NINE_BYTE);
    prev_soh    = sh_last_soh;
    sh_last_soh = is_soh;

    if (sh_phase == fmd_pkg::PH_HUNT) begin
      if (prev_soh && b == fmd_pkg::EIGHT_BYTE) begin
        sh_step     = fmd_pkg::HS_TAG8;
        sh_sum      = '0;
        sh_body     = '0;
        sh_declared = '0;
        sh_count    = 20'd1;
        open_field();
        sh_sum       = b;
        sh_tag       = 20'd8;
        sh_has_digit = 1'b1;
      end
      return;
    end

    sh_count = bump(sh_count);
    sh_sum   = sh_sum + b;
    if (sh_step == fmd_pkg::HS_BODY || sh_step == fmd_pkg::HS_CSUM) sh_body = bump(sh_body);

    if (sh_phase == fmd_pkg::PH_TAG) begin
      if (is_digit) begin
        sh_tag       = add_digit(sh_tag, b);
        sh_has_digit = 1'b1;
        return;
      end
      if (b == fmd_pkg::EQ_BYTE && sh_has_digit) begin
        hdr_ok = 1'b1;
        if (sh_step == fmd_pkg::HS_TAG8) hdr_ok = (sh_tag == 20'd8);
        else if (sh_step == fmd_pkg::HS_TAG9) hdr_ok = (sh_tag == 20'd9);
        else if (sh_tag == 20'd10) sh_step = fmd_pkg::HS_CSUM;
        if (hdr_ok) begin
          sh_phase = fmd_pkg::PH_VALUE;
          sh_num   = '0;
          return;
        end
      end
      sh_phase = fmd_pkg::PH_HUNT;
      post_event(fmd_pkg::EV_MALFORMED, 8'h00);
      return;
    end

    if (!is_soh) begin
      // length and checksum values must be decimal
      if (sh_step == fmd_pkg::HS_TAG9 || sh_step == fmd_pkg::HS_CSUM) begin
        if (!is_digit) begin
          sh_phase = fmd_pkg::PH_HUNT;
          post_event(fmd_pkg::EV_MALFORMED, 8'h00);
          return;
        end
        sh_num = add_digit(sh_num, b);
      end
      post_event(fmd_pkg::EV_VALUE, b);
      return;
    end

    case (sh_step)
      fmd_pkg::HS_TAG8: begin
        post_event(fmd_pkg::EV_FIELD_END, 8'h00);
        sh_step = fmd_pkg::HS_TAG9;
        open_field();
      end
      fmd_pkg::HS_TAG9: begin
        sh_declared = sh_num;
        if (sh_limit != '0 && sh_declared > sh_limit) begin
          sh_phase = fmd_pkg::PH_HUNT;
          post_event(fmd_pkg::EV_OVER_LIM, 8'h00);
        end else begin
          post_event(fmd_pkg::EV_FIELD_END, 8'h00);
          sh_step = fmd_pkg::HS_BODY;
          open_field();
        end
      end
      fmd_pkg::HS_BODY: begin
        post_event(fmd_pkg::EV_FIELD_END, 8'h00);
        open_field();
      end
      default: begin
        verdict = fmd_pkg::EV_MSG_OK;
        if (sh_sum_en && sh_sum_start != sh_num[7:0]) verdict = fmd_pkg::EV_BAD_SUM;
        else if (sh_len_en && sh_body_start != sh_declared) verdict = fmd_pkg::EV_BAD_LEN;
        sh_phase = fmd_pkg::PH_HUNT;
        post_event(verdict, 8'h00);
      end
    endcase
  endfunction

  task automatic note_mismatch(input string what);
    mismatch_count++;
    $display("mismatch at %0t: %s", $time, what);
  endtask

  // sender: bursts of random length, random gaps between them
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) parse_byte(s_axis_tdata_i);
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (gap_left != 0) begin
          gap_left--;
          s_axis_tvalid_i <= 1'b0;
        end else if (stream_bytes.size() != 0) begin
          s_axis_tvalid_i <= 1'b1;
          s_axis_tdata_i  <= stream_bytes.pop_front();
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 48);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
          end else begin
            burst_left--;
          end
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // receiver: check the taken word, then pick next ready from a rotating pattern
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (predicted_events.size() == 0) begin
          note_mismatch($sformatf("word with nothing predicted, event %0d", m_axis_tuser_o));
        end else begin
          want = predicted_events.pop_front();
          if (m_axis_tuser_o !== want.ev)
            note_mismatch($sformatf("event got %0d want %0d", m_axis_tuser_o, want.ev));
          if (m_axis_tdata_o[19:0] !== want.tag)
            note_mismatch($sformatf("tag got %0d want %0d", m_axis_tdata_o[19:0], want.tag));
          if (m_axis_tdata_o[27:20] !== want.data)
            note_mismatch($sformatf("data got %0h want %0h", m_axis_tdata_o[27:20],
                                    want.data));
          if (m_axis_tdata_o[47:28] !== want.nbytes)
            note_mismatch($sformatf("bytes got %0d want %0d", m_axis_tdata_o[47:28],
                                    want.nbytes));
          if (m_axis_tdata_o[55:48] !== want.sum)
            note_mismatch($sformatf("sum got %0d want %0d", m_axis_tdata_o[55:48], want.sum));
        end
      end
      case (cycle_count[8:7])
        2'd0:    m_axis_tready_i <= 1'b1;
        2'd1:    m_axis_tready_i <= ($urandom_range(0, 3) != 0);
        2'd2:    m_axis_tready_i <= (cycle_count[1:0] != 2'b11);
        default: m_axis_tready_i <= ($urandom_range(0, 1) != 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("fix_message_deframer_unit_tb failed");
      $finish;
    end
  end

  function automatic logic [7:0] value_byte();
    logic [7:0] r;
    r = $urandom_range(0, 255);
    return (r == fmd_pkg::SOH_BYTE) ? fmd_pkg::EQ_BYTE : r;
  endfunction

  function automatic void put_decimal(input int unsigned v, input int unsigned width);
    logic [7:0]  digs[$];
    int unsigned n;
    n = v;
    do begin
      digs.push_front(fmd_pkg::ZERO_BYTE + 8'(n % 10));
      n = n / 10;
    end while (n != 0);
    while (digs.size() < width) digs.push_front(fmd_pkg::ZERO_BYTE);
    foreach (digs[i]) frame_add(digs[i]);
  endfunction

  // one message with random body; some get a damage of one kind or are cut
  task automatic build_message();
    logic [7:0]  body[$];
    int unsigned kind, tagv, declared, sum, csum;
    kind = $urandom_range(0, 19);
    frame_buf.delete();
    repeat ($urandom_range(0, 3)) begin
      tagv = ($urandom_range(0, 15) == 0) ? 99999999 : $urandom_range(0, 300);
      if (tagv == 10) tagv = 11;
      put_decimal(tagv, 1);
      if (kind == 5) frame_add(LETTER_A);
      frame_add(fmd_pkg::EQ_BYTE);
      repeat ($urandom_range(0, 4)) frame_add(value_byte());
      frame_add(fmd_pkg::SOH_BYTE);
    end
    body = frame_buf;
    frame_buf.delete();
    declared = body.size();
    if (kind == 1) declared += $urandom_range(1, 3);

    frame_add(fmd_pkg::EIGHT_BYTE);
    if (kind == 4) frame_add(fmd_pkg::ZERO_BYTE);
    frame_add(fmd_pkg::EQ_BYTE);
    repeat ($urandom_range(0, 3)) frame_add(value_byte());
    frame_add(fmd_pkg::SOH_BYTE);
    frame_add((kind == 9) ? fmd_pkg::ZERO_BYTE + 8'd7 : fmd_pkg::NINE_BYTE);
    frame_add(fmd_pkg::EQ_BYTE);
    if (kind == 7) put_decimal(99999999, 1);
    else if (declared != 0 || $urandom_range(0, 1) != 0)
      put_decimal(declared, $urandom_range(1, 3));
    if (kind == 2) frame_add(DOT_BYTE);
    frame_add(fmd_pkg::SOH_BYTE);
    foreach (body[i]) frame_add(body[i]);

    sum = 0;
    foreach (frame_buf[i]) sum += frame_buf[i];
    sum  = sum % 256;
    csum = sum;
    if (kind == 0) csum = (sum + $urandom_range(1, 255)) % 256;
    if (kind == 8) csum = sum + 256;   // compared modulo 256
    frame_add(fmd_pkg::ZERO_BYTE + 8'd1);
    frame_add(fmd_pkg::ZERO_BYTE);
    frame_add(fmd_pkg::EQ_BYTE);
    put_decimal(csum, $urandom_range(1, 3));
    if (kind == 3) frame_add(LETTER_A);
    frame_add(fmd_pkg::SOH_BYTE);

    if (kind == 6) repeat ($urandom_range(1, frame_buf.size() - 1)) void'(frame_buf.pop_back());
    foreach (frame_buf[i]) stream_add(frame_buf[i]);
    items_sent += frame_buf.size();
  endtask

  task automatic run_random(input int unsigned n);
    int unsigned target;
    target = items_sent + n;
    while (items_sent < target) begin
      if ($urandom_range(0, 6) == 0) begin
        repeat ($urandom_range(1, 6)) begin
          stream_add(8'($urandom_range(0, 255)));
          items_sent++;
        end
        if ($urandom_range(0, 3) != 0) begin
          stream_add(fmd_pkg::SOH_BYTE);
          items_sent++;
        end
      end else begin
        build_message();
      end
    end
  endtask

  task automatic wait_idle();
    while (stream_bytes.size() != 0 || s_axis_tvalid_i || predicted_events.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // two halves with a full drain between them
  task automatic run_phase();
    run_random(36);
    wait_idle();
    run_random(36);
    wait_idle();
  endtask

  task automatic write_reg(input fmd_pkg::cfg_index_e idx, input logic [19:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      fmd_pkg::CFG_SUM_EN: sh_sum_en = val[0];
      fmd_pkg::CFG_LEN_EN: sh_len_en = val[0];
      default:             sh_limit  = val;
    endcase
  endtask

  task automatic configure(input logic sum_en, input logic len_en, input logic [19:0] limit);
    write_reg(fmd_pkg::CFG_SUM_EN, {19'd0, sum_en});
    write_reg(fmd_pkg::CFG_LEN_EN, {19'd0, len_en});
    write_reg(fmd_pkg::CFG_LIMIT, limit);
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // smallest good message with empty length value, then a bad tag byte,
    // an SOH inside a tag (which itself allows resync), and '=' with no digit
    stream_bytes = '{fmd_pkg::EIGHT_BYTE, fmd_pkg::EQ_BYTE, fmd_pkg::SOH_BYTE,
                     fmd_pkg::NINE_BYTE, fmd_pkg::EQ_BYTE, fmd_pkg::SOH_BYTE,
                     fmd_pkg::ZERO_BYTE + 8'd1, fmd_pkg::ZERO_BYTE, fmd_pkg::EQ_BYTE,
                     fmd_pkg::ZERO_BYTE + 8'd2, fmd_pkg::ZERO_BYTE + 8'd3,
                     fmd_pkg::ZERO_BYTE + 8'd7, fmd_pkg::SOH_BYTE,
                     fmd_pkg::EIGHT_BYTE, LETTER_A,
                     fmd_pkg::SOH_BYTE, fmd_pkg::EIGHT_BYTE, fmd_pkg::SOH_BYTE,
                     fmd_pkg::EIGHT_BYTE, fmd_pkg::EQ_BYTE, 8'hFF, 8'h00,
                     fmd_pkg::SOH_BYTE, fmd_pkg::EQ_BYTE};
    items_sent = stream_bytes.size();
    run_phase();

    configure(1'b0, 1'b1, SAT20);
    run_phase();
    configure(1'b1, 1'b0, 20'd12);
    run_phase();
    configure(1'b0, 1'b0, 20'd1);
    run_phase();
    configure(1'b1, 1'b1, 20'($urandom_range(2, 40)));
    run_phase();

    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("fix_message_deframer_unit_tb passed");
    end else begin
      $display("fix_message_deframer_unit_tb failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/fmd_pkg.sv
rtl/core/fmd_cfg_regs.sv
rtl/core/fmd_parser.sv
rtl/core/fmd_out_reg.sv
rtl/core/fix_message_deframer_unit.sv
verif/fix_message_deframer_unit_tb.sv
